/* hdl/wmaf_pkg.sv */
// shared types and constants for the warm-up moving average block
// no dependencies; imported by warmup_moving_average_with_fault

package wmaf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FAULT_ENABLE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAULT_LEVEL  = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_SIGN,
    ST_FINISH
  } wmaf_state_e;

endpackage

/* hdl/warmup_moving_average_with_fault.sv */
// warm-up boxcar moving average of altitude samples, with fault injection
// a fault beat passes from ST_IDLE through ST_FINISH into the output register; a mean
// also passes ST_UPDATE, ST_PREP, ST_DIV (the serial restoring divider, one quotient
// bit a cycle) and ST_SIGN; no new beat is taken while a result is in flight:
// the input stalls until the result enters the output register, which may wait
// reset: asynchronous, clears state, pointer, fill count, total, output valid and fault config; no sweep

module warmup_moving_average_with_fault #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wmaf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wmaf_pkg::DataW-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [wmaf_pkg::DataW-1:0] sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [wmaf_pkg::DataW-1:0] filtered_o,
  output logic                            from_fault_o
);
  import wmaf_pkg::*;

  localparam int unsigned PtrW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned TotW  = DataW + $clog2(WINDOW);
  localparam int unsigned CntW  = $clog2(TotW);

  wmaf_state_e state_q, state_d;

  logic                    fault_en_q;
  logic signed [DataW-1:0] fault_lvl_q;

  logic [PtrW-1:0]         wp_q, wp_d;
  logic [FillW-1:0]        fill_q, fill_d;
  logic signed [TotW-1:0]  total_q, total_d;
  logic signed [DataW-1:0] smp_q, smp_d;
  logic signed [DataW-1:0] ring_rd_q;
  logic                    ring_we;

  logic [FillW:0]          rem_q, rem_d;
  logic [TotW-1:0]         quo_q, quo_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    neg_q, neg_d;

  logic signed [DataW-1:0] res_q, res_d;
  logic                    res_flt_q, res_flt_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] filtered_q, filtered_d;
  logic                    from_fault_q, from_fault_d;

  logic                    in_beat;
  logic signed [DataW-1:0] old_smp;
  logic [FillW:0]          rem_sh;
  logic [TotW-1:0]         quo_neg;

  logic signed [DataW-1:0] ring_mem [WINDOW];

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_beat      = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filtered_q;
  assign from_fault_o = from_fault_q;

  // entries not yet filled read as zero
  assign old_smp = (fill_q == FillW'(WINDOW)) ? ring_rd_q : '0;
  assign rem_sh  = {rem_q[FillW-1:0], quo_q[TotW-1]};
  assign quo_neg = -quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_en_q  <= 1'b0;
      fault_lvl_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FAULT_ENABLE: fault_en_q  <= cfg_data_i[0];
        CFG_FAULT_LEVEL:  fault_lvl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= smp_q;
    end
    ring_rd_q <= ring_mem[wp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q        <= smp_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    cnt_q        <= cnt_d;
    neg_q        <= neg_d;
    res_q        <= res_d;
    res_flt_q    <= res_flt_d;
    filtered_q   <= filtered_d;
    from_fault_q <= from_fault_d;
  end

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    total_d      = total_q;
    smp_d        = smp_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    res_d        = res_q;
    res_flt_d    = res_flt_q;
    filtered_d   = filtered_q;
    from_fault_d = from_fault_q;
    ring_we      = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          smp_d = sample_i;
          if (fault_en_q) begin
            res_d     = fault_lvl_q;
            res_flt_d = 1'b1;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        ring_we = 1'b1;
        total_d = total_q - TotW'(old_smp) + TotW'(smp_q);
        wp_d    = (wp_q == PtrW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q != FillW'(WINDOW)) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = ST_PREP;
      end
      ST_PREP: begin
        neg_d   = total_q[TotW-1];
        quo_d   = total_q[TotW-1] ? -total_q : total_q;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // one restoring step: dividend bits shift out as quotient bits shift in
        if (rem_sh >= {1'b0, fill_q}) begin
          rem_d = rem_sh - {1'b0, fill_q};
          quo_d = {quo_q[TotW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[TotW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(TotW - 1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        res_d     = neg_q ? quo_neg[DataW-1:0] : quo_q[DataW-1:0];
        res_flt_d = 1'b0;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          filtered_d   = res_q;
          from_fault_d = res_flt_q;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WINDOW))
    else $error("fill count beyond window");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (fill_q != '0))
    else $error("divide by zero fill count");

  a_fault_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && fault_en_q) |=> ($stable(wp_q) && $stable(fill_q) && $stable(total_q)))
    else $error("state changed on a fault beat");

  a_mean_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !fault_en_q) |=> (state_q == ST_UPDATE))
    else $error("sample beat did not enter update");

endmodule
